### sv/rotation_matrix_to_quaternion_unit_macros.svh
// Assertion macros for the matrix-to-quaternion block.
// Used by the port checker only; no other dependencies.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH

// Implication checked on every edge outside reset
`define RMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define RMQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/rmq_pkg.sv
// Package for the matrix-to-quaternion block: widths, payload structs, branch codes.
// No dependencies.
package rmq_pkg;
  localparam int WORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int W = WORD_WIDTH_DEF;

  // Branch selection codes
  localparam logic [1:0] BR_X = 2'd0;
  localparam logic [1:0] BR_Y = 2'd1;
  localparam logic [1:0] BR_Z = 2'd2;
  localparam logic [1:0] BR_W = 2'd3;

  typedef struct packed {
    logic signed [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } in_item_t;

  typedef struct packed {
    logic signed [W-1:0] qx, qy, qz, qw;
    logic                invalid;
  } out_item_t;
endpackage

### sv/rmq_front.sv
// Front end: accepts matrices, picks the branch, forms radicand and numerators.
// Depends on rmq_pkg.
module rmq_front #(
  parameter int WW = rmq_pkg::WORD_WIDTH_DEF,
  parameter int FB = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  rmq_pkg::in_item_t       in_item,
  output logic                    o_vld,
  output logic [1:0]              o_br,
  output logic                    o_bad,
  output logic [WW+2:0]           o_rad,
  output logic signed [WW+1:0]    o_n0, o_n1, o_n2
);
  localparam int RW = WW + 3;
  logic signed [RW-1:0] a00, a11, a22, tr, one, rad;
  logic signed [WW+1:0] d12, s12, d20, s02, d01, s01;
  logic [1:0] br;
  logic signed [WW+1:0] n0, n1, n2;

  // Classification and sums
  always_comb begin
    a00 = RW'(in_item.m00);
    a11 = RW'(in_item.m11);
    a22 = RW'(in_item.m22);
    one = RW'(1) <<< FB;
    tr  = a00 + a11 + a22;
    d12 = (WW+2)'(in_item.m12) - (WW+2)'(in_item.m21);
    s12 = (WW+2)'(in_item.m12) + (WW+2)'(in_item.m21);
    d20 = (WW+2)'(in_item.m20) - (WW+2)'(in_item.m02);
    s02 = (WW+2)'(in_item.m02) + (WW+2)'(in_item.m20);
    d01 = (WW+2)'(in_item.m01) - (WW+2)'(in_item.m10);
    s01 = (WW+2)'(in_item.m01) + (WW+2)'(in_item.m10);
    priority if (tr > 0) begin
      br = rmq_pkg::BR_W; rad = tr + one;
      n0 = d12; n1 = d20; n2 = d01;
    end else if (a22 > a00 && a22 > a11) begin
      br = rmq_pkg::BR_Z; rad = one + a22 - a00 - a11;
      n0 = s02; n1 = s12; n2 = d01;
    end else if (a11 > a00) begin
      br = rmq_pkg::BR_Y; rad = one + a11 - a00 - a22;
      n0 = s01; n1 = s12; n2 = d20;
    end else begin
      br = rmq_pkg::BR_X; rad = one + a00 - a11 - a22;
      n0 = s01; n1 = s02; n2 = d12;
    end
  end

  // Output register, held while the pipe is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) o_vld <= 1'b0;
    else if (en) o_vld <= in_vld;
    if (en) begin
      o_br  <= br;
      o_bad <= (rad <= 0);
      o_rad <= (rad <= 0) ? '0 : rad[WW+2:0];
      o_n0 <= n0; o_n1 <= n1; o_n2 <= n2;
    end
  end
endmodule

### sv/rmq_back.sv
// Back end: pipelined square root, three pipelined dividers, saturation.
// Depends on rmq_pkg. One stage per result bit; stall freezes the whole pipe.
module rmq_back #(
  parameter int WW = rmq_pkg::WORD_WIDTH_DEF,
  parameter int FB = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    i_vld,
  input  logic [1:0]              i_br,
  input  logic                    i_bad,
  input  logic [WW+2:0]           i_rad,
  input  logic signed [WW+1:0]    i_n0, i_n1, i_n2,
  output logic                    o_vld,
  output rmq_pkg::out_item_t      o_item
);
  localparam int SW = (WW + 4 + FB) / 2;    // root width
  localparam int XW = 2 * SW;               // radicand << FB, whole bit pairs
  localparam int NS = SW;                   // root stages
  localparam int MW = WW + 1 + FB;          // numerator magnitude << FB
  localparam int QB = WW + 1;               // quotient bits kept (saturates above)
  localparam int DW = SW + 1;               // divisor 2*s
  localparam int ND = QB + 1;               // extra bit for rounding
  localparam int QMAX = (1 << (WW - 1)) - 1;

  // ---------------- square root pipeline ----------------
  logic [XW-1:0] sx_r [NS+1];
  logic [SW-1:0] sq_r [NS+1];
  logic [SW+1:0] sr_r [NS+1];
  logic          sv_r [NS+1];
  logic [1:0]    sb_r [NS+1];
  logic          sbad_r [NS+1];
  logic signed [WW+1:0] sn_r [NS+1][3];

  always_comb begin
    sx_r[0] = XW'(i_rad) << FB;
    sq_r[0] = '0; sr_r[0] = '0; sv_r[0] = i_vld; sb_r[0] = i_br; sbad_r[0] = i_bad;
    sn_r[0][0] = i_n0; sn_r[0][1] = i_n1; sn_r[0][2] = i_n2;
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [SW+1:0] rem_t, trial;
    logic [1:0]    pair;
    always_comb begin
      pair  = sx_r[k][2*(NS-1-k) +: 2];
      rem_t = {sr_r[k][SW-1:0], pair};
      trial = {sq_r[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k+1] <= 1'b0;
      else if (en) sv_r[k+1] <= sv_r[k];
      if (en) begin
        sx_r[k+1] <= sx_r[k];
        sb_r[k+1] <= sb_r[k]; sbad_r[k+1] <= sbad_r[k];
        sn_r[k+1] <= sn_r[k];
        if (rem_t >= trial) begin
          sr_r[k+1] <= rem_t - trial; sq_r[k+1] <= {sq_r[k][SW-2:0], 1'b1};
        end else begin
          sr_r[k+1] <= rem_t; sq_r[k+1] <= {sq_r[k][SW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- divider pipeline ----------------
  logic [ND-1:0]  dq_r [ND+1][3];
  logic [MW-1:0]  dm_r [ND+1][3];
  logic           dn_r [ND+1][3];
  logic [DW-1:0]  dd_r [ND+1];
  logic [SW-1:0]  ds_r [ND+1];
  logic           dv_r [ND+1];
  logic [1:0]     db_r [ND+1];
  logic           dbad_r [ND+1];
  logic           dz_r [ND+1][3];    // magnitude high bits overflow quotient

  always_comb begin
    dd_r[0] = {sq_r[NS], 1'b0};
    ds_r[0] = sq_r[NS]; dv_r[0] = sv_r[NS]; db_r[0] = sb_r[NS]; dbad_r[0] = sbad_r[NS];
    for (int j = 0; j < 3; j++) begin
      dn_r[0][j] = sn_r[NS][j][WW+1];
      dm_r[0][j] = MW'(dn_r[0][j] ? -sn_r[NS][j] : sn_r[NS][j]) << FB;
      dq_r[0][j] = '0;
      dz_r[0][j] = 1'b0;
    end
  end

  // restoring division, one quotient bit (MSB first) per stage, with
  // overflow detection: a quotient >= 2^ND is flagged and saturates
  for (genvar k = 0; k < ND; k++) begin : g_div
    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [MW+DW:0] sub_v;
      // divisor aligned to this stage's quotient bit
      always_comb begin
        sub_v = (MW+DW+1)'(dd_r[k]) << (ND - 1 - k);
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dn_r[k+1][j] <= dn_r[k][j];
          if (k == 0)
            dz_r[k+1][j] <= ((MW+DW+1)'(dm_r[k][j]) >= ((MW+DW+1)'(dd_r[k]) << ND));
          else
            dz_r[k+1][j] <= dz_r[k][j];
          if ((MW+DW+1)'(dm_r[k][j]) >= sub_v && !(k == 0 &&
              ((MW+DW+1)'(dm_r[k][j]) >= ((MW+DW+1)'(dd_r[k]) << ND)))) begin
            dm_r[k+1][j] <= MW'((MW+DW+1)'(dm_r[k][j]) - sub_v);
            dq_r[k+1][j] <= dq_r[k][j] | (ND'(1) << (ND - 1 - k));
          end else begin
            dm_r[k+1][j] <= dm_r[k][j];
            dq_r[k+1][j] <= dq_r[k][j];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else if (en) dv_r[k+1] <= dv_r[k];
      if (en) begin
        dd_r[k+1] <= dd_r[k]; ds_r[k+1] <= ds_r[k];
        db_r[k+1] <= db_r[k]; dbad_r[k+1] <= dbad_r[k];
      end
    end
  end

  // ---------------- rounding, saturation, assembly ----------------
  logic signed [WW-1:0] qv [3];
  logic signed [WW-1:0] hv;
  logic [ND:0] qr;
  logic [ND+DW:0] twice;
  logic [SW:0] hs;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      // round half up on magnitude: compare 2*rem with divisor
      twice = (ND+DW+1)'(dm_r[ND][j]) << 1;
      qr = (ND+1)'(dq_r[ND][j]) + (ND+1)'(twice >= (ND+DW+1)'(dd_r[ND]));
      if (dz_r[ND][j] || qr > (ND+1)'(QMAX)) qv[j] = dn_r[ND][j] ?
          WW'(-(QMAX + 1)) : ((qr > (ND+1)'(QMAX + 1) || dz_r[ND][j]) ? WW'(QMAX) :
          WW'(QMAX));
      else qv[j] = dn_r[ND][j] ? -WW'(qr) : WW'(qr);
      if (dn_r[ND][j] && !dz_r[ND][j] && qr == (ND+1)'(QMAX + 1)) qv[j] = WW'(-(QMAX+1));
    end
    hs = ((SW+1)'(ds_r[ND]) + (SW+1)'(1)) >> 1;
    hv = (hs > (SW+1)'(QMAX)) ? WW'(QMAX) : WW'(hs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_vld <= 1'b0;
    else if (en) o_vld <= dv_r[ND];
    if (en) begin
      o_item.invalid <= dbad_r[ND];
      if (dbad_r[ND]) begin
        o_item.qx <= '0; o_item.qy <= '0; o_item.qz <= '0; o_item.qw <= '0;
      end else begin
        unique case (db_r[ND])
          rmq_pkg::BR_X: begin
            o_item.qx <= hv; o_item.qy <= qv[0]; o_item.qz <= qv[1]; o_item.qw <= qv[2];
          end
          rmq_pkg::BR_Y: begin
            o_item.qx <= qv[0]; o_item.qy <= hv; o_item.qz <= qv[1]; o_item.qw <= qv[2];
          end
          rmq_pkg::BR_Z: begin
            o_item.qx <= qv[0]; o_item.qy <= qv[1]; o_item.qz <= hv; o_item.qw <= qv[2];
          end
          default: begin
            o_item.qx <= qv[0]; o_item.qy <= qv[1]; o_item.qz <= qv[2]; o_item.qw <= hv;
          end
        endcase
      end
    end
  end
endmodule

### sv/rmq_outq.sv
// Result queue: two-entry skid buffer on the back end's output.
// Depends on rmq_pkg.
module rmq_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               i_vld,
  input  rmq_pkg::out_item_t i_item,
  output logic               ready,
  output logic               empty,
  input  logic               pop,
  output rmq_pkg::out_item_t o_item
);
  rmq_pkg::out_item_t mem_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  logic       do_pop, do_push;

  // ready comes from the count alone, so pop never reaches the input side
  assign empty   = (cnt_r == 2'd0);
  assign ready   = (cnt_r != 2'd2);
  assign do_pop  = pop && !empty;
  assign do_push = i_vld && ready;
  assign o_item  = mem_r[rd_r];

  // Storage and pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
      if (do_push) wr_r <= ~wr_r;
      if (do_pop) rd_r <= ~rd_r;
    end
    if (do_push) mem_r[wr_r] <= i_item;
  end
endmodule

### sv/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion converter (Shepperd's method), Q2.14 default.
// Channels: input queue (in_push/in_full) of nine matrix elements; result
// queue (out_empty/out_pop) of qx, qy, qz, qw and invalid.
// Throughput: one item per cycle while results are taken.
// Path: classify register, sqrt stages (root width, 17 by default), divider
// stages (WORD_WIDTH+2), output register, then the two-entry result queue.
// The pipelined square root and the three pipelined dividers set the latency.
// A stalled receiver fills the two-entry result queue; the pipeline then
// freezes, front register included, and in_full rises, so no item is lost.
// in_full is high exactly while the result queue holds two items; it does
// not depend on out_pop, so a full stall ends only in the cycle after a pop.
// Reset (synchronous, rst_n low) empties all valid bits and the queue.
// Depends on rmq_pkg, rmq_front, rmq_back, rmq_outq.
module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rmq_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output rmq_pkg::out_item_t out_item
);
  localparam int WORD_WIDTH = rmq_pkg::W;

  logic f_vld, f_bad, b_vld, q_ready, en, acc;
  logic [1:0] f_br;
  logic [WORD_WIDTH+2:0] f_rad;
  logic signed [WORD_WIDTH+1:0] f_n0, f_n1, f_n2;
  rmq_pkg::out_item_t b_item;

  // Whole pipe advances when the queue can take the back end's output
  assign en      = q_ready;
  assign in_full = !en;
  assign acc     = in_push && en;

  rmq_front #(.WW(WORD_WIDTH), .FB(FRAC_BITS)) u_front (
    .clk, .rst_n, .en, .in_vld(acc), .in_item,
    .o_vld(f_vld), .o_br(f_br), .o_bad(f_bad), .o_rad(f_rad),
    .o_n0(f_n0), .o_n1(f_n1), .o_n2(f_n2)
  );

  rmq_back #(.WW(WORD_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk, .rst_n, .en, .i_vld(f_vld), .i_br(f_br), .i_bad(f_bad), .i_rad(f_rad),
    .i_n0(f_n0), .i_n1(f_n1), .i_n2(f_n2), .o_vld(b_vld), .o_item(b_item)
  );

  rmq_outq u_q (
    .clk, .rst_n, .i_vld(b_vld && en), .i_item(b_item), .ready(q_ready),
    .empty(out_empty), .pop(out_pop), .o_item(out_item)
  );
endmodule

### sv/rmq_checker.sv
// Port checker for the matrix-to-quaternion block, bound to the top level.
// Depends on rotation_matrix_to_quaternion_unit_macros.svh.
`include "rotation_matrix_to_quaternion_unit_macros.svh"
module rmq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input logic out_empty,
  input logic out_pop
);
  `RMQ_ASSERT_NXT(a_rst_empty, clk, 1'b1, !rst_n, out_empty)
  `RMQ_ASSERT_IMP(a_full_ok, clk, rst_n, in_full, !out_empty)
  `RMQ_ASSERT_NXT(a_no_pop_stays, clk, rst_n, !out_empty && !out_pop, !out_empty)
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_chk (
  .clk, .rst_n, .in_push, .in_full, .out_empty, .out_pop
);

### dv/rotation_matrix_to_quaternion_unit_tb.sv
// Testbench for rotation_matrix_to_quaternion_unit: directed and random matrices,
// each quaternion predicted in place and checked in order. Depends on rmq_pkg.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit_tb;
  localparam int W = rmq_pkg::W;
  localparam int FRAC = rmq_pkg::FRAC_BITS_DEF;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam longint QMAX = (64'sd1 << (W - 1)) - 1;
  localparam longint QMIN = -(64'sd1 << (W - 1));
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int N_RANDOM = 1200;

  logic clk, rst_n, in_push, in_full, out_empty, out_pop;
  rmq_pkg::in_item_t in_item;
  rmq_pkg::out_item_t out_item;

  rmq_pkg::out_item_t quat_due[$];
  int mismatches = 0;
  int cycles = 0;
  int push_idle = 0, pop_idle = 0;

  rotation_matrix_to_quaternion_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rotation_matrix_to_quaternion_unit_tb: errors");
      $finish;
    end
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  function automatic longint clamp(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint int_sqrt(input longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'sd3037000499;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // num * 2^FRAC / (2*root), nearest, ties away from zero
  function automatic longint scaled_div(input longint num, input longint root);
    longint den, mag, q;
    den = 2 * root;
    mag = (num < 0) ? -num : num;
    q = ((mag << FRAC) + den / 2) / den;
    return clamp((num < 0) ? -q : q);
  endfunction

  function automatic longint half_root(input longint root);
    longint h;
    h = (root + 1) >>> 1;
    return (h > QMAX) ? QMAX : h;
  endfunction

  function automatic rmq_pkg::out_item_t quat_of(input rmq_pkg::in_item_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, x, y, z, w, rad, rt, best;
    int pick;
    rmq_pkg::out_item_t r;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    x = 0; y = 0; z = 0; w = 0;
    r.invalid = 1'b0;
    if (a00 + a11 + a22 > 0) begin
      rt = int_sqrt((a00 + a11 + a22 + ONE) << FRAC);
      x = scaled_div(a12 - a21, rt);
      y = scaled_div(a20 - a02, rt);
      z = scaled_div(a01 - a10, rt);
      w = half_root(rt);
    end else begin
      // largest diagonal, lowest index on a tie
      pick = 0; best = a00;
      if (a11 > best) begin pick = 1; best = a11; end
      if (a22 > best) pick = 2;
      case (pick)
        0: rad = ONE + a00 - a11 - a22;
        1: rad = ONE + a11 - a00 - a22;
        default: rad = ONE + a22 - a00 - a11;
      endcase
      if (rad <= 0) begin
        r.invalid = 1'b1;
      end else begin
        rt = int_sqrt(rad << FRAC);
        case (pick)
          0: begin
            x = half_root(rt); y = scaled_div(a01 + a10, rt);
            z = scaled_div(a02 + a20, rt); w = scaled_div(a12 - a21, rt);
          end
          1: begin
            x = scaled_div(a01 + a10, rt); y = half_root(rt);
            z = scaled_div(a12 + a21, rt); w = scaled_div(a20 - a02, rt);
          end
          default: begin
            x = scaled_div(a02 + a20, rt); y = scaled_div(a12 + a21, rt);
            z = half_root(rt); w = scaled_div(a01 - a10, rt);
          end
        endcase
      end
    end
    r.qx = x[W-1:0]; r.qy = y[W-1:0]; r.qz = z[W-1:0]; r.qw = w[W-1:0];
    return r;
  endfunction

  // Result side: pop at random, compare at the rising edge
  always @(posedge clk) begin
    rmq_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (quat_due.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = quat_due.pop_front();
        if (out_item.qx !== want.qx)
          report($sformatf("qx %0d want %0d", out_item.qx, want.qx));
        if (out_item.qy !== want.qy)
          report($sformatf("qy %0d want %0d", out_item.qy, want.qy));
        if (out_item.qz !== want.qz)
          report($sformatf("qz %0d want %0d", out_item.qz, want.qz));
        if (out_item.qw !== want.qw)
          report($sformatf("qw %0d want %0d", out_item.qw, want.qw));
        if (out_item.invalid !== want.invalid)
          report($sformatf("invalid %0b want %0b", out_item.invalid, want.invalid));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(99) >= pop_idle);
  end

  typedef struct {
    rmq_pkg::in_item_t m;
    bit typed;
    rmq_pkg::out_item_t q;
  } matrix_row_t;

  matrix_row_t plan[$];

  function automatic rmq_pkg::in_item_t mat(input longint d0, d1, d2, d3, d4, d5, d6,
                                            d7, d8);
    rmq_pkg::in_item_t m;
    m.m00 = W'(d0); m.m01 = W'(d1); m.m02 = W'(d2);
    m.m10 = W'(d3); m.m11 = W'(d4); m.m12 = W'(d5);
    m.m20 = W'(d6); m.m21 = W'(d7); m.m22 = W'(d8);
    return m;
  endfunction

  function automatic rmq_pkg::out_item_t quat(input longint x, y, z, w, input bit bad);
    rmq_pkg::out_item_t q;
    q.qx = W'(x); q.qy = W'(y); q.qz = W'(z); q.qw = W'(w); q.invalid = bad;
    return q;
  endfunction

  function automatic matrix_row_t row(input rmq_pkg::in_item_t m, input bit typed = 0,
                                      input rmq_pkg::out_item_t q = '0);
    matrix_row_t r;
    r.m = m; r.typed = typed; r.q = q;
    return r;
  endfunction

  function automatic rmq_pkg::in_item_t random_rotation_like();
    rmq_pkg::in_item_t m;
    m = '0;
    for (int k = 0; k < 9; k++)
      m[k*W +: W] = W'($signed($urandom_range(32768)) - 16384);
    return m;
  endfunction

  // Push one item, holding push until accepted
  task automatic push_item(input rmq_pkg::in_item_t m, input rmq_pkg::out_item_t want);
    while ($urandom_range(99) < push_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= m;
    quat_due.push_back(want);
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rmq_pkg::in_item_t m;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed matrices: identity, half-turns, extremes, ties
    plan.push_back(row(mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1,
                       quat(0, 0, 0, 16384, 0)));
    plan.push_back(row(mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1,
                       quat(16384, 0, 0, 0, 0)));
    plan.push_back(row(mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1,
                       quat(0, 16384, 0, 0, 0)));
    plan.push_back(row(mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1,
                       quat(0, 0, 16384, 0, 0)));
    plan.push_back(row(mat(0, 0, 0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(row(mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768)));
    plan.push_back(row(mat(-16384, 0, 0, 0, 32767, 0, 0, 0, 32767)));
    plan.push_back(row(mat(-20000, 5, 5, 5, -20000, 5, 5, 5, -20000)));
    plan.push_back(row(mat(32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767)));
    plan.push_back(row(mat(32767, -32768, 32767, 32767, -32768, -32768, -32768, 32767, -32768)));
    plan.push_back(row(mat(-1, 32767, 32767, 32767, -1, 32767, 32767, 32767, -1)));
    plan.push_back(row(mat(-32768, -32768, -32768, -32768, 0, -32768, -32768, -32768, 0)));
    plan.push_back(row(mat(1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0)));
    plan.push_back(row(mat(0, 100, 200, 300, 0, 400, 500, 600, 0)));
    plan.push_back(row(mat(-100, 1, 2, 3, 50, 4, 5, 6, 50)));
    plan.push_back(row(mat(-100, 1, 2, 3, -200, 4, 5, 6, 50)));
    plan.push_back(row(mat(16384, -32768, -32768, 32767, -16384, 32767, -32768, 32767,
                           -16384)));
    plan.push_back(row(mat(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767,
                           32767)));
    plan.push_back(row(mat(-5, 0, 0, 0, -5, 0, 0, 0, -5)));

    push_idle = 29; pop_idle = 53;
    foreach (plan[i]) push_item(plan[i].m, plan[i].typed ? plan[i].q : quat_of(plan[i].m));

    // Random: three idling phases, mostly elements in -16384..16384, some raw noise
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin push_idle = 53; pop_idle = 29; end
      if (n == 2 * N_RANDOM / 3) begin push_idle = 0; pop_idle = 0; end
      if ($urandom_range(3) == 0)
        for (int k = 0; k < 9; k++) m[k*W +: W] = W'($urandom);
      else
        m = random_rotation_like();
      push_item(m, quat_of(m));
    end
    in_push <= 1'b0;

    while (quat_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("rotation_matrix_to_quaternion_unit_tb: clean");
    else $display("rotation_matrix_to_quaternion_unit_tb: errors");
    $finish;
  end
endmodule
